// File: hw/rtl/binned_mean_accumulator_unit_assert.svh
// Assertion macros shared by the binned mean accumulator modules.
`ifndef BINNED_MEAN_ACCUMULATOR_UNIT_ASSERT_SVH
`define BINNED_MEAN_ACCUMULATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("binned mean accumulator check failed");

// Consequent must hold in the cycle after the antecedent.
`define BMA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("binned mean accumulator check failed");

`endif

// File: hw/rtl/bma_pkg.sv
package bma_pkg;

    localparam int NBINS      = 64;
    localparam int COUNT_BITS = 24;
    localparam int SUM_W      = 56;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 6;
    localparam int BIN_W      = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int NB_W       = $clog2(NBINS + 1);
    localparam int ENTRY_W    = SUM_W + COUNT_BITS;
    localparam int BW_W       = 31;

    // shared divider: long runs cover a bin sum, short runs a 32-bit position
    localparam int DIV_N_W    = SUM_W;
    localparam int DIV_D_W    = (COUNT_BITS > BW_W) ? COUNT_BITS : BW_W;
    localparam int DIV_SHORT  = VAL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH  = 2'd2;

    localparam logic signed [VAL_W-1:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST = 32'sd4194304;
    localparam logic [BW_W-1:0]         BIN_WIDTH_RST  = 31'd65536;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] sample_x;
        logic signed [VAL_W-1:0] sample_y;
        logic                    y_missing;
    } t_request;

    typedef struct packed {
        logic [IDX_W-1:0]        bin_index;
        logic signed [VAL_W-1:0] bin_mean;
        logic                    mean_missing;
        logic                    status;
        logic                    last_bin;
    } t_result;

    typedef struct packed {
        logic accept;
        logic nb_clear;
        logic nb_load;
        logic div_nb;
        logic div_add;
        logic div_mean;
        logic add_read;
        logic add_write;
        logic bin_clr;
        logic bin_inc;
        logic fin_read;
        logic emit_err;
        logic emit_empty;
        logic emit_mean;
        logic clear_store;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_bad;
        logic nb_zero;
        logic skip_add;
        logic is_finish;
        logic div_done;
        logic target_ok;
        logic rd_empty;
        logic bin_last;
    } t_dp_stat;

endpackage

// File: hw/rtl/bma_ram.sv
module bma_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bma_div.sv
module bma_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_long,
    input  logic [bma_pkg::DIV_N_W-1:0] i_dividend,
    input  logic [bma_pkg::DIV_D_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [bma_pkg::DIV_N_W-1:0] o_quot
);

    import bma_pkg::*;

    `include "binned_mean_accumulator_unit_assert.svh"

    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [DIV_N_W-1:0]   r_quot, n_quot;
    logic [DIV_D_W-1:0]   r_rem, n_rem;
    logic [DIV_D_W-1:0]   r_div, n_div;

    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W+1:0]   trial;
    logic                 fits;

    always_comb begin
        rem_sh = {r_rem, r_quot[DIV_N_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_div};
        fits   = !trial[DIV_D_W+1];

        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_done = 1'b0;
        if (i_start) begin
            n_div = i_divisor;
            n_rem = '0;
            if (i_long) begin
                n_quot = i_dividend;
                n_cnt  = DIV_CNT_W'(DIV_N_W);
            end else begin
                // short run: align the 32-bit dividend to the top
                n_quot = {i_dividend[DIV_SHORT-1:0], {(DIV_N_W-DIV_SHORT){1'b0}}};
                n_cnt  = DIV_CNT_W'(DIV_SHORT);
            end
        end else if (r_cnt != '0) begin
            n_quot = {r_quot[DIV_N_W-2:0], fits};
            n_rem  = fits ? trial[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            n_done = (r_cnt == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `BMA_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, r_cnt != '0, !i_start)

endmodule

// File: hw/rtl/bma_datapath.sv
module bma_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bma_pkg::t_request              i_req,
    input  logic                           i_cfg_we,
    input  logic [bma_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bma_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  bma_pkg::t_dp_cmd               i_cmd,
    output bma_pkg::t_dp_stat              o_stat,
    output logic                           o_valid,
    output bma_pkg::t_result               o_result
);

    import bma_pkg::*;

    logic signed [VAL_W-1:0] r_range_low;
    logic signed [VAL_W-1:0] r_range_high;
    logic [BW_W-1:0]         r_bin_width;
    t_request                r_req;
    logic [NB_W-1:0]         r_nb;
    logic [BIN_W-1:0]        r_bin;
    logic [BIN_W-1:0]        r_addr;
    logic [NBINS-1:0]        r_valid;
    logic                    r_rd_valid;
    logic                    r_neg;
    t_result                 r_out;
    logic                    r_out_valid;

    logic [VAL_W:0]          span;
    logic [VAL_W:0]          x_off;
    logic                    cfg_bad;
    logic                    div_start;
    logic [DIV_N_W-1:0]      div_dividend;
    logic [DIV_D_W-1:0]      div_divisor;
    logic                    div_done;
    logic [DIV_N_W-1:0]      quot;
    logic [NB_W-1:0]         nb_new;
    logic [NB_W-1:0]         nb_m1;
    logic [VAL_W-1:0]        bin_q;
    logic [VAL_W-1:0]        nb_ext;
    logic                    in_range;
    logic                    on_edge;
    logic [BIN_W-1:0]        target_addr;
    logic                    ram_re;
    logic [BIN_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [SUM_W-1:0]        rd_sum;
    logic [COUNT_BITS-1:0]   rd_cnt;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W:0]          new_sum;
    logic                    bin_last;
    logic [VAL_W-1:0]        mean;

    always_comb begin
        span    = {r_range_high[VAL_W-1], r_range_high}
                - {r_range_low[VAL_W-1], r_range_low};
        x_off   = {r_req.sample_x[VAL_W-1], r_req.sample_x}
                - {r_range_low[VAL_W-1], r_range_low};
        // non-positive span or zero width gives no bins
        cfg_bad = span[VAL_W] || (span == '0) || (r_bin_width == '0);

        rd_sum  = r_rd_valid ? ram_rdata[ENTRY_W-1:COUNT_BITS] : '0;
        rd_cnt  = r_rd_valid ? ram_rdata[COUNT_BITS-1:0] : '0;
        mag     = rd_sum[SUM_W-1] ? (SUM_W'(0) - rd_sum) : rd_sum;
        new_sum = {rd_sum[SUM_W-1], rd_sum}
                + {{(SUM_W+1-VAL_W){r_req.sample_y[VAL_W-1]}}, r_req.sample_y};

        div_start = i_cmd.div_nb || i_cmd.div_add || i_cmd.div_mean;
        if (i_cmd.div_mean) begin
            div_dividend = mag;
            div_divisor  = DIV_D_W'(rd_cnt);
        end else begin
            div_dividend = {{(DIV_N_W-VAL_W){1'b0}},
                            (i_cmd.div_nb ? span[VAL_W-1:0] : x_off[VAL_W-1:0])};
            div_divisor  = DIV_D_W'(r_bin_width);
        end

        nb_new = (quot > DIV_N_W'(NBINS)) ? NB_W'(NBINS) : quot[NB_W-1:0];
        nb_m1  = r_nb - NB_W'(1);

        bin_q    = quot[VAL_W-1:0];
        nb_ext   = VAL_W'(r_nb);
        in_range = bin_q < nb_ext;
        // a sample exactly on the upper edge joins the last bin unless the bin count was capped
        on_edge  = (bin_q == nb_ext) && (r_req.sample_x == r_range_high);
        target_addr = in_range ? bin_q[BIN_W-1:0] : nb_m1[BIN_W-1:0];

        ram_re    = i_cmd.add_read || i_cmd.fin_read;
        ram_raddr = i_cmd.add_read ? target_addr : r_bin;
        ram_we    = i_cmd.add_write && (rd_cnt != COUNT_MAX)
                 && (new_sum[SUM_W] == new_sum[SUM_W-1]);
        ram_wdata = {new_sum[SUM_W-1:0], rd_cnt + COUNT_BITS'(1)};

        bin_last = (NB_W'(r_bin) == nb_m1);
        mean     = r_neg ? (VAL_W'(0) - quot[VAL_W-1:0]) : quot[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
            r_bin_width  <= BIN_WIDTH_RST;
            r_nb         <= '0;
            r_bin        <= '0;
            r_valid      <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RANGE_LOW:  r_range_low  <= i_cfg_wdata;
                    REG_RANGE_HIGH: r_range_high <= i_cfg_wdata;
                    REG_BIN_WIDTH:  r_bin_width  <= i_cfg_wdata[BW_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.nb_clear) begin
                r_nb <= '0;
            end else if (i_cmd.nb_load) begin
                r_nb <= nb_new;
            end
            if (i_cmd.bin_clr) begin
                r_bin <= '0;
            end else if (i_cmd.bin_inc) begin
                r_bin <= r_bin + BIN_W'(1);
            end
            if (ram_re) begin
                r_rd_valid <= r_valid[ram_raddr];
            end
            // empty store: drop every valid flag at once
            if (i_cmd.clear_store) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            r_out_valid <= i_cmd.emit_err || i_cmd.emit_empty || i_cmd.emit_mean;
        end

        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.add_read) begin
            r_addr <= target_addr;
        end
        if (i_cmd.div_mean) begin
            r_neg <= rd_sum[SUM_W-1];
        end
        if (i_cmd.emit_err) begin
            r_out.bin_index    <= '0;
            r_out.bin_mean     <= '0;
            r_out.mean_missing <= 1'b0;
            r_out.status       <= 1'b1;
            r_out.last_bin     <= 1'b1;
        end else if (i_cmd.emit_empty || i_cmd.emit_mean) begin
            r_out.bin_index    <= IDX_W'(r_bin);
            r_out.bin_mean     <= i_cmd.emit_mean ? mean : '0;
            r_out.mean_missing <= i_cmd.emit_empty;
            r_out.status       <= 1'b0;
            r_out.last_bin     <= bin_last;
        end
    end

    bma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_long     (i_cmd.div_mean),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    bma_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NBINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.cfg_bad   = cfg_bad;
    assign o_stat.nb_zero   = (r_nb == '0);
    assign o_stat.skip_add  = r_req.y_missing || x_off[VAL_W];
    assign o_stat.is_finish = r_req.req_type;
    assign o_stat.div_done  = div_done;
    assign o_stat.target_ok = in_range || on_edge;
    assign o_stat.rd_empty  = (rd_cnt == '0);
    assign o_stat.bin_last  = bin_last;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: hw/rtl/bma_ctrl.sv
module bma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cfg_we,
    input  bma_pkg::t_dp_stat i_stat,
    output bma_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    import bma_pkg::*;

    `include "binned_mean_accumulator_unit_assert.svh"

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_NB_START = 4'd1;
    localparam logic [3:0] ST_NB_WAIT  = 4'd2;
    localparam logic [3:0] ST_DISPATCH = 4'd3;
    localparam logic [3:0] ST_ADD_WAIT = 4'd4;
    localparam logic [3:0] ST_ADD_WR   = 4'd5;
    localparam logic [3:0] ST_FIN_READ = 4'd6;
    localparam logic [3:0] ST_FIN_CHK  = 4'd7;
    localparam logic [3:0] ST_FIN_WAIT = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_nb_ok, n_nb_ok;
    t_dp_cmd    cmd;
    logic [2:0] div_starts;

    always_comb begin
        n_state = r_state;
        n_nb_ok = r_nb_ok;
        cmd     = '0;
        // any register write invalidates the cached bin count
        if (i_cfg_we) begin
            n_nb_ok = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    n_state    = r_nb_ok ? ST_DISPATCH : ST_NB_START;
                end
            end
            ST_NB_START: begin
                if (i_stat.cfg_bad) begin
                    cmd.nb_clear = 1'b1;
                    n_nb_ok      = 1'b1;
                    n_state      = ST_DISPATCH;
                end else begin
                    cmd.div_nb = 1'b1;
                    n_state    = ST_NB_WAIT;
                end
            end
            ST_NB_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.nb_load = 1'b1;
                    n_nb_ok     = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.is_finish) begin
                    if (i_stat.nb_zero) begin
                        cmd.emit_err    = 1'b1;
                        cmd.clear_store = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        cmd.bin_clr = 1'b1;
                        n_state     = ST_FIN_READ;
                    end
                end else if (i_stat.nb_zero || i_stat.skip_add) begin
                    n_state = ST_IDLE;
                end else begin
                    cmd.div_add = 1'b1;
                    n_state     = ST_ADD_WAIT;
                end
            end
            ST_ADD_WAIT: begin
                if (i_stat.div_done) begin
                    if (i_stat.target_ok) begin
                        cmd.add_read = 1'b1;
                        n_state      = ST_ADD_WR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ADD_WR: begin
                cmd.add_write = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_FIN_READ: begin
                cmd.fin_read = 1'b1;
                n_state      = ST_FIN_CHK;
            end
            ST_FIN_CHK: begin
                if (i_stat.rd_empty) begin
                    cmd.emit_empty = 1'b1;
                    if (i_stat.bin_last) begin
                        cmd.clear_store = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        cmd.bin_inc = 1'b1;
                        n_state     = ST_FIN_READ;
                    end
                end else begin
                    cmd.div_mean = 1'b1;
                    n_state      = ST_FIN_WAIT;
                end
            end
            ST_FIN_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.emit_mean = 1'b1;
                    if (i_stat.bin_last) begin
                        cmd.clear_store = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        cmd.bin_inc = 1'b1;
                        n_state     = ST_FIN_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nb_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nb_ok <= n_nb_ok;
        end
    end

    assign div_starts = {cmd.div_nb, cmd.div_add, cmd.div_mean};
    assign o_cmd      = cmd;
    assign o_busy     = (r_state != ST_IDLE);

    `BMA_ASSERT_IMP(a_one_div_start, i_clk, i_rst_n, 1'b1, $countones(div_starts) <= 1)
    `BMA_ASSERT_IMP(a_clear_on_emit, i_clk, i_rst_n, cmd.clear_store, cmd.emit_err || cmd.emit_empty || cmd.emit_mean)
    `BMA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, cmd.accept, r_state != ST_IDLE)

endmodule

// File: hw/rtl/binned_mean_accumulator_unit.sv
// Binned mean accumulator.
// Requests enter on i_req, taken at a clock edge with start high and busy low.
// An add request files sample_y into bin floor((sample_x - range_low) / bin_width);
// a finish request emits one result per bin on o_result (a single error result
// when there are no bins), each marked by o_valid for a single cycle, then empties
// the store. Registers are written on i_cfg_we with i_cfg_addr / i_cfg_wdata,
// while busy is low: a rule on the user that the block itself does not enforce.
// An add request steps through dispatch, 32 steps of the shared radix-2 divider,
// and a store read and write; a missing sample_y, a sample_x below range_low or
// no bins end it at dispatch, and an x past the last bin ends it after the divide.
// The first request after reset or after a register write first works out the bin
// count with the same divider, unless the settings are unusable. A finish request
// reads each bin from the store and, when the bin holds samples, divides its sum by
// its count in a 56-step divide. Results leave through an output register, so the
// next request may be taken in the cycle the last result is shown. The receiver
// cannot stall; results are not held back. Reset restores the register defaults
// and empties the store at once through per-bin valid flags; there is no clearing pass.
module binned_mean_accumulator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bma_pkg::t_request              i_req,
    input  logic                           i_cfg_we,
    input  logic [bma_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bma_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_valid,
    output bma_pkg::t_result               o_result
);

    import bma_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bma_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cfg_we (i_cfg_we),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

// File: tb/binned_mean_accumulator_unit_tb.sv
module binned_mean_accumulator_unit_tb;
    import bma_pkg::*;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    localparam int RANDOM_ITEMS  = 100;
    localparam int CALM_TAIL     = 20;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 20000;

    class bin_mean_scoreboard;
        localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
        localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));

        logic signed [VAL_W-1:0] range_low;
        logic signed [VAL_W-1:0] range_high;
        logic [BW_W-1:0]         bin_width;
        longint                  bin_sum[NBINS];
        longint                  bin_cnt[NBINS];
        t_result                 pending_means[$];
        int                      errors;
        int                      checked;
        int                      samples;
        int                      finishes;

        function new();
            range_low  = RANGE_LOW_RST;
            range_high = RANGE_HIGH_RST;
            bin_width  = BIN_WIDTH_RST;
            errors     = 0;
            checked    = 0;
            samples    = 0;
            finishes   = 0;
            clear_bins();
        endfunction

        function void clear_bins();
            for (int k = 0; k < NBINS; k++) begin
                bin_sum[k] = 0;
                bin_cnt[k] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
            case (addr)
                REG_RANGE_LOW:  range_low  = data;
                REG_RANGE_HIGH: range_high = data;
                REG_BIN_WIDTH:  bin_width  = data[BW_W-1:0];
                default: ;
            endcase
        endfunction

        // zero when the settings are unusable
        function longint active_bins();
            longint span;
            longint bw;
            longint n;
            if (range_low >= range_high || bin_width == 0) return 0;
            span = longint'(range_high) - longint'(range_low);
            bw   = bin_width;
            n    = span / bw;
            return (n > NBINS) ? NBINS : n;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        function void note_request(t_request req);
            longint  nb;
            longint  xv;
            longint  yv;
            longint  d;
            longint  b;
            longint  bw;
            longint  target;
            longint  s;
            t_result r;
            nb = active_bins();
            if (req.req_type == REQ_ADD) begin
                samples++;
                if (req.y_missing || nb == 0) return;
                xv = $signed(req.sample_x);
                yv = $signed(req.sample_y);
                bw = bin_width;
                d  = xv - longint'(range_low);
                if (d < 0) return;
                b = d / bw;
                target = -1;
                if (b < nb) target = b;
                else if (b == nb && xv == longint'(range_high)) target = nb - 1;
                if (target < 0 || target >= NBINS) return;
                if (bin_cnt[target] >= COUNT_MAX) return;
                s = bin_sum[target] + yv;
                if (s > SUM_HI || s < SUM_LO) return;
                bin_sum[target] = s;
                bin_cnt[target]++;
                return;
            end
            finishes++;
            if (nb == 0) begin
                r = '0;
                r.status   = 1'b1;
                r.last_bin = 1'b1;
                pending_means.push_back(r);
            end else begin
                for (longint k = 0; k < nb; k++) begin
                    r = '0;
                    r.bin_index    = IDX_W'(k);
                    r.mean_missing = (bin_cnt[k] == 0);
                    r.bin_mean     = r.mean_missing ? '0 : VAL_W'(bin_sum[k] / bin_cnt[k]);
                    r.last_bin     = (k + 1 == nb);
                    pending_means.push_back(r);
                end
            end
            clear_bins();
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual bin %0d mean %0d",
                         $time, got.bin_index, $signed(got.bin_mean));
                errors++;
                return;
            end
            want = pending_means.pop_front();
            checked++;
            compare_field("bin_index", want.bin_index, got.bin_index);
            compare_field("bin_mean", $signed(want.bin_mean), $signed(got.bin_mean));
            compare_field("mean_missing", want.mean_missing, got.mean_missing);
            compare_field("status", want.status, got.status);
            compare_field("last_bin", want.last_bin, got.last_bin);
        endfunction

        function void flag_leftovers();
            if (pending_means.size() != 0) begin
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, pending_means.size());
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_request              i_req       = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  o_valid;
    t_result               o_result;

    bin_mean_scoreboard sb;
    int settings_used;

    binned_mean_accumulator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // start is left high between back-to-back requests; idle_burst and drain lower it
    task automatic send_request(t_request r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        if ($urandom_range(0, 1)) begin
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
        end
        repeat ($urandom_range(1, 19)) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(addr, data);
    endtask

    task automatic configure(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                             logic [CFG_W-1:0] width);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        write_reg(REG_BIN_WIDTH, width);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // hold until every mean has arrived, then let a trailing add finish
    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_request make_add(logic [31:0] x, logic [31:0] y, logic miss);
        t_request r;
        r.req_type  = REQ_ADD;
        r.sample_x  = x;
        r.sample_y  = y;
        r.y_missing = miss;
        return r;
    endfunction

    function automatic t_request make_finish();
        t_request r;
        r.req_type  = REQ_FINISH;
        r.sample_x  = $urandom;
        r.sample_y  = $urandom;
        r.y_missing = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic t_request random_add();
        t_request r;
        longint   lo;
        longint   span;
        int       pick;
        lo   = sb.range_low;
        span = longint'(sb.range_high) - lo;
        pick = $urandom_range(0, 19);
        r.req_type  = REQ_ADD;
        r.y_missing = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 15))
            0:       r.sample_y = 32'h7FFF_FFFF;
            1:       r.sample_y = 32'h8000_0000;
            default: r.sample_y = $urandom;
        endcase
        if (span <= 0 || pick < 2) r.sample_x = $urandom;
        else if (pick == 2) r.sample_x = sb.range_high;
        else if (pick == 3) r.sample_x = sb.range_low;
        else r.sample_x = 32'(lo + longint'($urandom_range(0, 32'(span))));
        return r;
    endfunction

    task automatic random_config();
        longint nbins;
        longint w;
        longint lo;
        longint hi;
        longint maxlo;
        if ($urandom_range(0, 7) == 0) begin
            // unconstrained: often unusable settings
            configure($urandom, $urandom,
                      ($urandom_range(0, 3) == 0) ? {1'($urandom_range(0, 1)), 31'd0} : $urandom);
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                nbins = 1;
                w     = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
            end else begin
                nbins = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
                w     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                    : $urandom_range(1, 32'h0010_0000);
            end
            maxlo = Q_MAX - (nbins + 1) * w;
            lo    = Q_MIN + longint'($urandom_range(0, 32'(maxlo - Q_MIN)));
            hi    = lo + nbins * w + longint'($urandom_range(0, 32'(w - 1)));
            configure(32'(lo), 32'(hi), {1'($urandom_range(0, 1)), 31'(w)});
        end
    endtask

    initial begin
        int       item_total;
        int       phase_len;
        bit       idle_on;
        t_request r;

        sb = new();
        settings_used = 1;
        item_total = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 64 bins of width 1.0 from 0.0
        send_request(make_add(32'h0000_0000, 32'h7FFF_FFFF, 1'b0));
        send_request(make_add(32'h0000_0000, 32'h8000_0000, 1'b0));
        send_request(make_add(32'h0003_FFFF, 32'h0005_8000, 1'b0));
        send_request(make_add(32'h0040_0000, 32'hFFFD_0000, 1'b0));   // exact upper edge
        send_request(make_add(32'hFFFF_FFFF, 32'h0001_0000, 1'b0));
        send_request(make_add(32'h7FFF_FFFF, 32'h0001_0000, 1'b0));
        send_request(make_add(32'h8000_0000, 32'h0001_0000, 1'b0));
        send_request(make_add(32'h0001_0000, 32'h1234_5678, 1'b1));
        send_request(make_add(32'h0001_8000, 32'hFFFF_FFFC, 1'b0));
        send_request(make_add(32'h0001_4000, 32'h0000_0001, 1'b0));   // mean rounds toward zero
        send_request(make_finish());
        send_request(make_finish());
        drain();

        // widest range, widest bin: upper edge lands in the last of two bins
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(make_add(32'h7FFF_FFFF, 32'h0002_0000, 1'b0));
        send_request(make_add(32'h8000_0000, 32'hFFFE_0000, 1'b0));
        send_request(make_finish());
        drain();

        // bin count capped: the upper edge falls outside
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        send_request(make_add(32'h7FFF_FFFF, 32'h0003_0000, 1'b0));
        send_request(make_add(32'h8000_0000, 32'h0004_0000, 1'b0));
        send_request(make_finish());
        drain();

        configure(32'h0000_0005, 32'h0000_0005, 32'h0001_0000);
        send_request(make_add(32'h0000_0005, 32'h0001_0000, 1'b0));
        send_request(make_finish());
        drain();

        configure(32'h0000_0000, 32'h0040_0000, 32'h8000_0000);
        send_request(make_finish());
        drain();

        write_reg(REG_UNUSED, $urandom);
        configure(32'h0000_0000, 32'h0000_000A, 32'h0000_000B);
        send_request(make_add(32'h0000_0000, 32'h0001_0000, 1'b0));
        send_request(make_finish());
        drain();

        configure(32'h0000_0000, 32'h0000_0003, 32'h0000_0001);
        send_request(make_add(32'h0000_0003, 32'h0007_0000, 1'b0));
        send_request(make_finish());
        drain();

        while (item_total < RANDOM_ITEMS) begin
            random_config();
            phase_len = $urandom_range(4, 20);
            idle_on   = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < phase_len; i++) begin
                if (i == phase_len - 1 || $urandom_range(0, 19) == 0) r = make_finish();
                else r = random_add();
                send_request(r);
                item_total++;
                if (idle_on && item_total < RANDOM_ITEMS - CALM_TAIL &&
                    $urandom_range(0, 2) == 0)
                    idle_burst();
            end
            drain();
        end

        sb.flag_leftovers();
        $display("Run covered %0d sample and %0d finish requests across %0d register settings;",
                 sb.samples, sb.finishes, settings_used);
        $display("%0d bin results were compared against the predicted means.", sb.checked);
        if (sb.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
